// ===== rtl/tdbc_pkg.sv =====
// Shared types, constants and helpers for the TTL DMA buffer cache.
// No dependencies; tdbc_ctrl and ttl_dma_buffer_cache import this package.
package tdbc_pkg;

  localparam int NUM_ENTRIES = 96;
  localparam int QUEUE_DEPTH = 256;
  localparam int ADDR_BITS   = 32;

  localparam int ENT_AW = $clog2(NUM_ENTRIES);
  localparam int QS_W   = $clog2(QUEUE_DEPTH);
  localparam int QA_W   = $clog2(2 * QUEUE_DEPTH);
  localparam int CNT_W  = 7;
  localparam int IDX_W  = 7;
  localparam int TTL_W  = 6;

  localparam logic [TTL_W-1:0] TTL_LONG  = TTL_W'(60);
  localparam logic [TTL_W-1:0] TTL_SHORT = TTL_W'(2);

  localparam logic [ADDR_BITS-1:0] ALIGN_MASK = ~ADDR_BITS'('hF);

  // Register reset values
  localparam logic [6:0]  SHORT_COUNT_RST = 7'd48;
  localparam logic [6:0]  TOTAL_COUNT_RST = 7'd64;
  localparam logic [15:0] SHORT_BYTES_RST = 16'(144 * 9);
  localparam logic [15:0] LONG_BYTES_RST  = 16'(160 * 9);

  // Register indexes
  localparam logic [1:0] CFG_SHORT_COUNT = 2'd0;
  localparam logic [1:0] CFG_TOTAL_COUNT = 2'd1;
  localparam logic [1:0] CFG_SHORT_BYTES = 2'd2;
  localparam logic [1:0] CFG_LONG_BYTES  = 2'd3;

  // Opcodes
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_REBUILD = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_NOFREE = 2'd1;
  localparam logic [1:0] ERR_SIZE   = 2'd2;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [ADDR_BITS-1:0] dev_addr;
    logic [15:0]          request_bytes;
    logic                 long_lived;
    logic [IDX_W-1:0]     hint_index;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic                 fill_start;
    logic [IDX_W-1:0]     buffer_index;
    logic [15:0]          byte_offset;
    logic [ADDR_BITS-1:0] fill_source;
    logic [15:0]          fill_length;
    logic [1:0]           error_code;
  } out_t;

  // Class bounds and sizes, as seen by the controller
  typedef struct packed {
    logic [CNT_W-1:0] s;
    logic [CNT_W-1:0] t;
    logic [15:0]      short_bytes;
    logic [15:0]      long_bytes;
  } cfg_t;

  // One buffer's record in the entry memory
  typedef struct packed {
    logic [ADDR_BITS-1:0] src;
    logic [TTL_W-1:0]     ttl;
    logic [QS_W-1:0]      pos;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  // True when a buffer starting at src of the given size holds the range
  function automatic logic covers(input logic [ADDR_BITS-1:0] src,
                                  input logic [ADDR_BITS-1:0] addr,
                                  input logic [15:0] req,
                                  input logic [15:0] size);
    logic [ADDR_BITS-1:0] diff;
    logic [15:0]          room;
    diff = addr - src;
    room = size - req;
    covers = (req <= size) && (addr >= src) && (diff <= ADDR_BITS'(room));
  endfunction

endpackage

// ===== rtl/tdbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tdbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tdbc_ctrl.sv =====
// Sequencer of the buffer cache: searches, hits, allocation, ageing walk
// and queue rebuild over the entry and free-queue memories.
// Depends on tdbc_pkg.
module tdbc_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  tdbc_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tdbc_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tdbc_pkg::out_t                 out_data,
  output logic [tdbc_pkg::ENT_AW-1:0]    ent_raddr,
  input  logic [tdbc_pkg::ENT_W-1:0]     ent_rdata,
  output logic                           ent_we,
  output logic [tdbc_pkg::ENT_AW-1:0]    ent_waddr,
  output logic [tdbc_pkg::ENT_W-1:0]     ent_wdata,
  output logic [tdbc_pkg::QA_W-1:0]      q_raddr,
  input  logic [tdbc_pkg::IDX_W-1:0]     q_rdata,
  output logic                           q_we,
  output logic [tdbc_pkg::QA_W-1:0]      q_waddr,
  output logic [tdbc_pkg::IDX_W-1:0]     q_wdata
);
  import tdbc_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SRD   = 4'd1;
  localparam logic [3:0] ST_SCHK  = 4'd2;
  localparam logic [3:0] ST_LSCAN = 4'd3;
  localparam logic [3:0] ST_WALK  = 4'd4;
  localparam logic [3:0] ST_HIT   = 4'd5;
  localparam logic [3:0] ST_DQ1   = 4'd6;
  localparam logic [3:0] ST_DQ2   = 4'd7;
  localparam logic [3:0] ST_MISS  = 4'd8;
  localparam logic [3:0] ST_AL1   = 4'd9;
  localparam logic [3:0] ST_AL2   = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  localparam logic [CNT_W-1:0] NUM_CNT = CNT_W'(NUM_ENTRIES);

  logic [3:0]             state;
  in_t                    item;
  out_t                   res;
  logic [QS_W-1:0]        shead, stail, lhead, ltail;
  logic [CNT_W-1:0]       iss;
  logic                   p_v;
  logic [ENT_AW-1:0]      p_i;
  logic                   walk_reb;
  logic                   longp;
  logic [ENT_AW-1:0]      h_i;
  ent_t                   h_ent;
  logic                   h_long;
  logic [IDX_W-1:0]       dq_tv;
  logic                   m_long;
  logic [ENT_AW-1:0]      al_idx;
  logic [NUM_ENTRIES-1:0] vld;
  logic                   vld_q;

  ent_t             cur;
  logic [CNT_W-1:0] lim;
  logic             iss_go;
  logic             pc_short;
  logic [QS_W-1:0]  head_c;
  logic [QS_W-1:0]  htail, hhead;
  logic             hit_now;
  logic             tick_enq;
  logic             deq;
  logic             ml;
  logic [15:0]      msize;
  logic [QS_W-1:0]  mtail, mhead;
  logic [ENT_AW-1:0] al_sel;
  logic             load_out;

  // Entries never written since reset read as zero
  assign cur = vld_q ? ent_t'(ent_rdata) : '0;

  assign in_stall = (state != ST_IDLE);
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  // Walk limits and per-entry helpers
  assign lim      = (state == ST_WALK && walk_reb) ? NUM_CNT : cfg.t;
  assign iss_go   = (iss < lim);
  assign pc_short = (CNT_W'(p_i) < cfg.s);
  assign head_c   = pc_short ? shead : lhead;
  assign hit_now  = p_v && covers(cur.src, item.dev_addr, item.request_bytes,
                                  cfg.long_bytes);
  assign tick_enq = (state == ST_WALK) && !walk_reb && p_v && (cur.ttl == TTL_W'(1));

  // Queue pointers of the class that was hit
  assign htail = h_long ? ltail : stail;
  assign hhead = h_long ? lhead : shead;
  assign deq   = (h_ent.ttl == '0) && (htail != hhead);

  // Miss class selection
  assign ml    = longp && item.long_lived && (ltail != lhead);
  assign msize = ml ? cfg.long_bytes : cfg.short_bytes;
  assign mtail = ml ? ltail : stail;
  assign mhead = ml ? lhead : shead;

  assign al_sel = (q_rdata < IDX_W'(NUM_ENTRIES)) ? ENT_AW'(q_rdata) : '0;

  // Memory port steering
  always_comb begin
    ent_raddr = iss[ENT_AW-1:0];
    ent_we    = 1'b0;
    ent_waddr = p_i;
    ent_wdata = '0;
    q_raddr   = '0;
    q_we      = 1'b0;
    q_waddr   = '0;
    q_wdata   = '0;
    unique case (state)
      ST_IDLE, ST_SRD: begin
        ent_raddr = ENT_AW'(item.hint_index);
      end
      ST_WALK: begin
        if (p_v && walk_reb) begin
          ent_we = 1'b1;
          if (CNT_W'(p_i) < cfg.t) begin
            q_we    = 1'b1;
            q_wdata = IDX_W'(p_i);
            if (pc_short) begin
              ent_wdata = {{ADDR_BITS{1'b0}}, {TTL_W{1'b0}}, QS_W'(p_i)};
              q_waddr   = {1'b0, QS_W'(p_i)};
            end else begin
              ent_wdata = {{ADDR_BITS{1'b0}}, {TTL_W{1'b0}},
                           QS_W'(p_i) - QS_W'(cfg.s)};
              q_waddr   = {1'b1, QS_W'(p_i) - QS_W'(cfg.s)};
            end
          end else begin
            ent_wdata = {{ADDR_BITS{1'b0}}, {TTL_W{1'b0}}, cur.pos};
          end
        end else if (p_v && cur.ttl != '0) begin
          ent_we    = 1'b1;
          ent_wdata = {cur.src, cur.ttl - TTL_W'(1), tick_enq ? head_c : cur.pos};
          if (tick_enq) begin
            q_we    = 1'b1;
            q_waddr = {!pc_short, head_c};
            q_wdata = IDX_W'(p_i);
          end
        end
      end
      ST_HIT: begin
        ent_we    = 1'b1;
        ent_waddr = h_i;
        ent_wdata = {h_ent.src, h_long ? TTL_LONG : TTL_SHORT, h_ent.pos};
        q_raddr   = {h_long, htail};
      end
      ST_DQ1: begin
        ent_raddr = ENT_AW'(q_rdata);
        if (h_ent.pos != htail) begin
          q_we    = 1'b1;
          q_waddr = {h_long, h_ent.pos};
          q_wdata = q_rdata;
        end
      end
      ST_DQ2: begin
        ent_we    = 1'b1;
        ent_waddr = ENT_AW'(dq_tv);
        ent_wdata = {cur.src, cur.ttl, h_ent.pos};
      end
      ST_MISS: begin
        q_raddr = {ml, mtail};
      end
      ST_AL1: begin
        ent_raddr = al_sel;
      end
      ST_AL2: begin
        ent_we    = 1'b1;
        ent_waddr = al_idx;
        ent_wdata = {item.dev_addr & ALIGN_MASK, TTL_SHORT, cur.pos};
      end
      default: begin
      end
    endcase
  end

  // Valid bits stand in for the zero reset of the entry memory
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (ent_we) begin
        vld[ent_waddr] <= 1'b1;
      end
      vld_q <= (CNT_W'(ent_raddr) < NUM_CNT) ? vld[ent_raddr] : 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      shead     <= '0;
      stail     <= '0;
      lhead     <= '0;
      ltail     <= '0;
      p_v       <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            res  <= '0;
            p_v  <= 1'b0;
            iss  <= '0;
            unique case (in_data.opcode)
              OP_REQUEST: begin
                longp <= in_data.long_lived || (in_data.hint_index >= cfg.s);
                if (in_data.long_lived || (in_data.hint_index >= cfg.s)) begin
                  iss   <= cfg.s;
                  state <= ST_LSCAN;
                end else begin
                  state <= ST_SRD;
                end
              end
              OP_TICK: begin
                walk_reb <= 1'b0;
                state    <= ST_WALK;
              end
              OP_REBUILD: begin
                walk_reb <= 1'b1;
                state    <= ST_WALK;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_SRD: state <= ST_SCHK;
        ST_SCHK: begin
          if (covers(cur.src, item.dev_addr, item.request_bytes, cfg.short_bytes)) begin
            h_i    <= ENT_AW'(item.hint_index);
            h_ent  <= cur;
            h_long <= 1'b0;
            state  <= ST_HIT;
          end else begin
            state <= ST_MISS;
          end
        end
        ST_LSCAN: begin
          if (hit_now) begin
            h_i    <= p_i;
            h_ent  <= cur;
            h_long <= 1'b1;
            p_v    <= 1'b0;
            state  <= ST_HIT;
          end else if (iss_go) begin
            p_v <= 1'b1;
            p_i <= iss[ENT_AW-1:0];
            iss <= iss + CNT_W'(1);
          end else begin
            p_v <= 1'b0;
            if (!p_v) state <= ST_MISS;
          end
        end
        ST_WALK: begin
          if (tick_enq) begin
            if (pc_short) shead <= shead + QS_W'(1);
            else          lhead <= lhead + QS_W'(1);
          end
          if (iss_go) begin
            p_v <= 1'b1;
            p_i <= iss[ENT_AW-1:0];
            iss <= iss + CNT_W'(1);
          end else begin
            p_v <= 1'b0;
            if (!p_v) begin
              if (walk_reb) begin
                stail <= '0;
                ltail <= '0;
                shead <= QS_W'(cfg.s);
                lhead <= QS_W'(cfg.t - cfg.s);
              end
              state <= ST_DONE;
            end
          end
        end
        ST_HIT: begin
          res.hit          <= 1'b1;
          res.buffer_index <= IDX_W'(h_i);
          res.byte_offset  <= 16'(item.dev_addr - h_ent.src);
          state            <= deq ? ST_DQ1 : ST_DONE;
        end
        ST_DQ1: begin
          dq_tv <= q_rdata;
          if ((h_ent.pos != htail) && (q_rdata < IDX_W'(NUM_ENTRIES))) begin
            state <= ST_DQ2;
          end else begin
            if (h_long) ltail <= ltail + QS_W'(1);
            else        stail <= stail + QS_W'(1);
            state <= ST_DONE;
          end
        end
        ST_DQ2: begin
          if (h_long) ltail <= ltail + QS_W'(1);
          else        stail <= stail + QS_W'(1);
          state <= ST_DONE;
        end
        ST_MISS: begin
          m_long <= ml;
          if (item.request_bytes > msize) begin
            res.error_code <= ERR_SIZE;
            state          <= ST_DONE;
          end else if (mtail == mhead) begin
            res.error_code <= ERR_NOFREE;
            state          <= ST_DONE;
          end else begin
            if (ml) ltail <= ltail + QS_W'(1);
            else    stail <= stail + QS_W'(1);
            state <= ST_AL1;
          end
        end
        ST_AL1: begin
          al_idx <= al_sel;
          state  <= ST_AL2;
        end
        ST_AL2: begin
          res.fill_start   <= 1'b1;
          res.buffer_index <= IDX_W'(al_idx);
          res.byte_offset  <= {12'b0, item.dev_addr[3:0]};
          res.fill_source  <= item.dev_addr & ALIGN_MASK;
          res.fill_length  <= m_long ? cfg.long_bytes : cfg.short_bytes;
          state            <= ST_DONE;
        end
        ST_DONE: begin
          if (load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!ent_we && !q_we))
    else $error("memory write while idle");

  a_hit_xor_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.hit && out_data.fill_start))
    else $error("result both hit and fill");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.error_code != ERR_OK) |->
      (!out_data.hit && !out_data.fill_start && out_data.fill_length == '0))
    else $error("error result carries payload");

  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    ent_we |-> (CNT_W'(ent_waddr) < NUM_CNT))
    else $error("entry write out of range");

endmodule

// ===== rtl/ttl_dma_buffer_cache.sv =====
// TTL DMA buffer cache: one transaction at a time. Long-class searches, ticks and
// rebuilds walk the entry memory, which gives one read a cycle. The next
// transaction is taken in the cycle after the result is registered.
// Reset: synchronous; registers to their reset values, queues empty, entries
// read as zero through valid bits cleared by reset, no clearing pass.
// Holds the configuration registers and both memories; needs tdbc_pkg,
// tdbc_ram and tdbc_ctrl.
module ttl_dma_buffer_cache (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tdbc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tdbc_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import tdbc_pkg::*;

  logic [6:0]  short_count, total_count;
  logic [15:0] short_bytes, long_bytes;
  logic [CNT_W-1:0] t_cnt;
  cfg_t cfg;

  logic [ENT_AW-1:0] ent_raddr, ent_waddr;
  logic [ENT_W-1:0]  ent_rdata, ent_wdata;
  logic              ent_we;
  logic [QA_W-1:0]   q_raddr, q_waddr;
  logic [IDX_W-1:0]  q_rdata, q_wdata;
  logic              q_we;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      short_count <= SHORT_COUNT_RST;
      total_count <= TOTAL_COUNT_RST;
      short_bytes <= SHORT_BYTES_RST;
      long_bytes  <= LONG_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHORT_COUNT: short_count <= cfg_data[6:0];
        CFG_TOTAL_COUNT: total_count <= cfg_data[6:0];
        CFG_SHORT_BYTES: short_bytes <= cfg_data;
        CFG_LONG_BYTES:  long_bytes  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Class bounds, clamped to the pool size
  assign t_cnt = (total_count > CNT_W'(NUM_ENTRIES)) ? CNT_W'(NUM_ENTRIES) : total_count;
  assign cfg.t = t_cnt;
  assign cfg.s = (short_count > t_cnt) ? t_cnt : short_count;
  assign cfg.short_bytes = short_bytes;
  assign cfg.long_bytes  = long_bytes;

  tdbc_ram #(.WIDTH(ENT_W), .DEPTH(NUM_ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // Both free queues share one memory, class in the top address bit
  tdbc_ram #(.WIDTH(IDX_W), .DEPTH(2 * QUEUE_DEPTH)) u_q_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  tdbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ent_raddr (ent_raddr),
    .ent_rdata (ent_rdata),
    .ent_we    (ent_we),
    .ent_waddr (ent_waddr),
    .ent_wdata (ent_wdata),
    .q_raddr   (q_raddr),
    .q_rdata   (q_rdata),
    .q_we      (q_we),
    .q_waddr   (q_waddr),
    .q_wdata   (q_wdata)
  );

endmodule
